### rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the RTL.
// Uses clk and rst_n of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, reset included
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked out of reset only
`define SST_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### rtl/sst_pkg.sv
// sst_pkg: types and constants of the strided shaker sort block.
// No dependencies.
package sst_pkg;

  localparam int SST_MAX_ELEMENTS = 64;
  localparam int SST_DATA_WIDTH   = 32;
  localparam int SST_IO_WIDTH     = 32;

  typedef struct packed {
    logic signed [SST_IO_WIDTH-1:0] value;
    logic                           last;
  } sst_in_req_t;

  typedef struct packed {
    logic signed [SST_IO_WIDTH-1:0] value_res;
    logic                           last_res;
  } sst_out_res_t;

  typedef enum logic {
    SST_LOAD,
    SST_EMIT
  } sst_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // insert the broadcast value in order
    logic drain;  // shift the row one place toward cell 0
  } sst_ctrl_t;

endpackage

### rtl/sst_cell.sv
// sst_cell: one slot of the sorting row; holds one value and an occupied bit.
// Depends on sst_pkg.
module sst_cell #(
  parameter int DATA_WIDTH = sst_pkg::SST_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sst_pkg::sst_ctrl_t           ctrl,
  input  logic signed [DATA_WIDTH-1:0] ins_val,
  input  logic signed [DATA_WIDTH-1:0] prev_val,
  input  logic                         prev_gt,
  input  logic                         prev_occ,
  input  logic signed [DATA_WIDTH-1:0] next_val,
  input  logic                         next_occ,
  output logic signed [DATA_WIDTH-1:0] val,
  output logic                         gt,
  output logic                         occ
);

  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                         occ_r, occ_nxt;

  assign gt  = occ_r && (val_r > ins_val);
  assign val = val_r;
  assign occ = occ_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctrl.load) begin
      // this slot or an empty one: take the left neighbor if it moves, else the new value
      if (gt || !occ_r) begin
        val_nxt = prev_gt ? prev_val : ins_val;
      end
      occ_nxt = occ_r | prev_occ;
    end else if (ctrl.drain) begin
      val_nxt = next_val;
      occ_nxt = next_occ;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

### rtl/strided_shaker_sort.sv
// strided_shaker_sort: loads a set, emits it in ascending signed order.
// Loading accepts one request per cycle; each insert lands in the cell row at once.
// After the last request the set of n values leaves one per cycle while out_stall
// is low, the first in the cycle after.
// Synchronous active-low reset empties the cell row and the count; no clear pass.
// Depends on sst_pkg, sst_cell and assert_macros.svh.
`include "assert_macros.svh"

module strided_shaker_sort #(
  parameter int MAX_ELEMENTS = sst_pkg::SST_MAX_ELEMENTS,
  parameter int DATA_WIDTH   = sst_pkg::SST_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sst_pkg::sst_in_req_t  in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sst_pkg::sst_out_res_t out_res
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IO_W  = sst_pkg::SST_IO_WIDTH;

  sst_pkg::sst_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  sst_pkg::sst_ctrl_t  ctrl;
  logic                in_acc, out_acc, full;

  logic signed [DATA_WIDTH-1:0] ins_val;
  logic signed [DATA_WIDTH-1:0] val_w [MAX_ELEMENTS];
  logic                         gt_w  [MAX_ELEMENTS];
  logic                         occ_w [MAX_ELEMENTS];

  // sign-extend or truncate the input word to the stored width
  generate
    if (DATA_WIDTH > IO_W) begin : g_in_ext
      assign ins_val = $signed({{(DATA_WIDTH-IO_W){in_req.value[IO_W-1]}}, in_req.value});
    end else begin : g_in_cut
      assign ins_val = $signed(in_req.value[DATA_WIDTH-1:0]);
    end
  endgenerate

  generate
    if (DATA_WIDTH >= IO_W) begin : g_out_cut
      assign out_res.value_res = $signed(val_w[0][IO_W-1:0]);
    end else begin : g_out_ext
      assign out_res.value_res = $signed({{(IO_W-DATA_WIDTH){1'b0}}, val_w[0]});
    end
  endgenerate

  assign out_res.last_res = (cnt_r == CNT_W'(1));
  assign full     = (cnt_r == CNT_W'(MAX_ELEMENTS));
  assign in_stall  = (state_r == sst_pkg::SST_EMIT);
  assign out_valid = (state_r == sst_pkg::SST_EMIT);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::SST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ctrl.load  = 1'b0;
    ctrl.drain = 1'b0;
    unique case (state_r)
      sst_pkg::SST_LOAD: begin
        if (in_acc) begin
          // a value beyond capacity is dropped, its last flag still counts
          if (!full) begin
            ctrl.load = 1'b1;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
          if (in_req.last) begin
            state_nxt = sst_pkg::SST_EMIT;
          end
        end
      end
      sst_pkg::SST_EMIT: begin
        if (out_acc) begin
          ctrl.drain = 1'b1;
          cnt_nxt    = cnt_r - CNT_W'(1);
          if (out_res.last_res) begin
            state_nxt = sst_pkg::SST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = sst_pkg::SST_LOAD;
      end
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] pv, nv;
      logic                         pg, po, no;
      if (i == 0) begin : g_head
        assign pv = '0;
        assign pg = 1'b0;
        assign po = 1'b1;
      end else begin : g_body
        assign pv = val_w[i-1];
        assign pg = gt_w[i-1];
        assign po = occ_w[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_tail
        assign nv = '0;
        assign no = 1'b0;
      end else begin : g_link
        assign nv = val_w[i+1];
        assign no = occ_w[i+1];
      end
      sst_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .ins_val  (ins_val),
        .prev_val (pv),
        .prev_gt  (pg),
        .prev_occ (po),
        .next_val (nv),
        .next_occ (no),
        .val      (val_w[i]),
        .gt       (gt_w[i]),
        .occ      (occ_w[i])
      );
    end
  endgenerate

  `SST_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (cnt_r == '0 && !out_valid), "reset did not empty the block")
  `SST_ASSERT_RUN(a_cnt_range, cnt_r <= CNT_W'(MAX_ELEMENTS), "element count beyond capacity")
  `SST_ASSERT_RUN(a_emit_nonempty, out_valid |-> (cnt_r != '0), "result offered from empty set")
  `SST_ASSERT_RUN(a_head_occ, occ_w[0] == (cnt_r != '0), "head cell occupancy disagrees with count")
  `SST_ASSERT_RUN(a_last_ends, (out_acc && out_res.last_res) |=> (!out_valid && cnt_r == '0), "set did not end after final result")

endmodule

### verif/tb.sv
// tb: self-checking testbench for strided_shaker_sort (load a set, emit it sorted).
// Predicts each sorted set with its own gap-2 then gap-1 shaker sort and checks
// every result in order. Depends on sst_pkg and the RTL of the block.
module tb;

  localparam int STORE_DEPTH = sst_pkg::SST_MAX_ELEMENTS;
  localparam int DRAIN_CYCLES = 2 * sst_pkg::SST_MAX_ELEMENTS + 16;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sst_pkg::sst_in_req_t  in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sst_pkg::sst_out_res_t out_res;

  // predictor state
  logic signed [sst_pkg::SST_IO_WIDTH-1:0] held_values [STORE_DEPTH];
  int                                      held_count = 0;
  sst_pkg::sst_out_res_t                   expected_sorted [$];

  int error_count = 0;
  int requests_sent = 0;
  int sets_closed = 0;
  int results_checked = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  strided_shaker_sort DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // compare-swap of two held entries, signed order
  function automatic void order_pair(input int lo, input int hi);
    logic signed [sst_pkg::SST_IO_WIDTH-1:0] tmp;
    if (lo >= STORE_DEPTH || hi >= STORE_DEPTH) return;
    if (held_values[lo] > held_values[hi]) begin
      tmp = held_values[lo];
      held_values[lo] = held_values[hi];
      held_values[hi] = tmp;
    end
  endfunction

  // one shaker run over indices 0, gap, 2*gap, ...; window narrows from both ends
  function automatic void shaker_run(input int n, input int gap);
    int lo_end;
    int hi_end;
    int i;
    if (n == 0 || gap == 0) return;
    lo_end = 0;
    hi_end = ((n - 1) / gap) * gap;
    while (lo_end <= hi_end) begin
      for (i = lo_end; i < hi_end; i += gap) order_pair(i, i + gap);
      if (hi_end < gap) break;
      hi_end -= gap;
      for (i = hi_end; i > lo_end; i -= gap) order_pair(i - gap, i);
      lo_end += gap;
    end
  endfunction

  function automatic void predict_request(input sst_pkg::sst_in_req_t req);
    sst_pkg::sst_out_res_t res;
    int k;
    // full store drops the element, but last still closes the set
    if (held_count < STORE_DEPTH) begin
      held_values[held_count] = req.value;
      held_count++;
    end
    if (req.last) begin
      shaker_run(held_count, 2);
      shaker_run(held_count, 1);
      for (k = 0; k < held_count; k++) begin
        res.value_res = held_values[k];
        res.last_res  = (k == held_count - 1);
        expected_sorted.push_back(res);
      end
      held_count = 0;
      sets_closed++;
    end
  endfunction

  function automatic logic signed [sst_pkg::SST_IO_WIDTH-1:0] rand_value();
    logic signed [sst_pkg::SST_IO_WIDTH-1:0] v;
    case ($urandom_range(3))
      0: v = $signed($urandom_range(16)) - 8;  // dense duplicates
      1: v = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                               : 32'sh8000_0000 + $urandom_range(3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // sends one request, returns at the edge where it was accepted
  task automatic send_request(input logic signed [sst_pkg::SST_IO_WIDTH-1:0] val,
                              input logic is_last);
    sst_pkg::sst_in_req_t req;
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.value = val;
    req.last  = is_last;
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    predict_request(req);
  endtask

  task automatic send_set(input int size);
    int i;
    for (i = 0; i < size; i++) send_request(rand_value(), i == size - 1);
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
  endtask

  task automatic test_directed_sets();
    send_request(32'sh7FFF_FFFF, 1'b0);
    send_request(32'sh8000_0000, 1'b0);
    send_request(32'sh0000_0000, 1'b0);
    send_request(-32'sd1, 1'b0);
    send_request(32'sd1, 1'b1);
    send_request(-32'sd5, 1'b1);  // single-element set
    send_request(32'sd3, 1'b0);
    send_request(32'sd3, 1'b0);
    send_request(-32'sd3, 1'b0);
    send_request(32'sd3, 1'b1);
    for (int i = 1; i <= 5; i++) send_request(i, i == 5);
    for (int i = 3; i >= -3; i--) send_request(i, i == -3);
  endtask

  task automatic test_store_overflow();
    send_set(STORE_DEPTH);
    // three extra elements dropped; the last one still closes the set
    send_set(STORE_DEPTH + 3);
  endtask

  task automatic test_random_sets(input int budget);
    int start;
    start = requests_sent;
    while (requests_sent - start < budget) begin
      if ($urandom_range(24) == 0) send_set(STORE_DEPTH - $urandom_range(8));
      else send_set($urandom_range(1, 10));
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    sst_pkg::sst_out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sorted.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_res.value_res));
      end else begin
        want = expected_sorted.pop_front();
        results_checked++;
        if (out_res.value_res !== want.value_res)
          report_mismatch($sformatf("value_res %0d, expected %0d",
                                    out_res.value_res, want.value_res));
        if (out_res.last_res !== want.last_res)
          report_mismatch($sformatf("last_res %b, expected %b (value %0d)",
                                    out_res.last_res, want.last_res, want.value_res));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_directed_sets();
    set_idling(37, 37);
    test_store_overflow();
    set_idling(0, 0);
    test_random_sets(75);
    set_idling(67, 0);
    test_random_sets(75);
    set_idling(0, 67);
    test_random_sets(75);
    set_idling(37, 37);
    test_random_sets(75);
    in_valid <= 1'b0;

    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests in %0d sets, checked %0d sorted results.",
             requests_sent, sets_closed, results_checked);
    $display("Covered field extremes, duplicates, full and overflowing store, four idle mixes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("Timeout: %0d results still expected", expected_sorted.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
